[design/base64_stream_encoder_core_macros.svh]
// Assertion macros for the base64 stream encoder checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define B64_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define B64_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/b64enc_pkg.sv]
// Shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies.
package b64enc_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;

    typedef struct packed {
        logic [2:0][5:0] codes;
        logic [1:0]      ncodes;
        logic [1:0]      npads;
        logic            fin;
    } job_t;

    function automatic logic [6:0] map6(input logic [5:0] v);
        logic [6:0] t;
        logic [6:0] r;
        t = {1'b0, v};
        if (v < 6'd26) begin
            r = 7'd65 + t;
        end else if (v < 6'd52) begin
            r = 7'd71 + t;
        end else if (v < 6'd62) begin
            r = t - 7'd4;
        end else if (v == 6'd62) begin
            r = 7'd43;
        end else begin
            r = 7'd47;
        end
        return r;
    endfunction

endpackage

[design/base64_stream_encoder_core.sv]
// Top level of the streaming base64 encoder with '=' padding.
// Instantiates b64enc_front, b64enc_queue and b64enc_back; uses b64enc_pkg.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_data_byte[7:0], s_final_byte
//  m_      | out       | m_valid / m_ready | m_symbol[6:0], m_item_done, m_message_done
//
// One character leaves per cycle from the output register unless m_ready stalls;
// a byte yields 1 to 4 characters, emitted in turn (4 per 3 bytes in a message,
// plus flush and pads at its end). The front takes a byte every cycle
// while the job queue (QUEUE_DEPTH entries) has room. Sync reset clears the
// residual bits, phase, queue pointers and output valid. A stall on m_ready
// fills the queue and then drops s_ready.
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_symbol,
    output logic       m_item_done,
    output logic       m_message_done
);
    import b64enc_pkg::*;

    job_t new_job;
    job_t head_job;
    logic q_empty, q_full;
    logic accept;
    logic pop;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    b64enc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .final_byte (s_final_byte),
        .job        (new_job)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .din     (new_job),
        .rd_en   (pop),
        .dout    (head_job),
        .empty   (q_empty),
        .full    (q_full)
    );

    b64enc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job            (head_job),
        .job_valid      (!q_empty),
        .job_pop        (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_item_done    (m_item_done),
        .m_message_done (m_message_done)
    );

endmodule

[design/b64enc_front.sv]
// Front end: accepts bytes, holds the residual bits and the symbol phase,
// and turns each byte into a job of 6-bit codes and pad count. Uses b64enc_pkg.
module b64enc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output b64enc_pkg::job_t  job
);
    import b64enc_pkg::*;

    logic [3:0]  residual_bits_reg, residual_bits_next;
    logic [2:0]  residual_count_reg, residual_count_next;
    logic [1:0]  symbol_phase_reg, symbol_phase_next;
    logic [11:0] acc;
    logic [5:0]  g0, g1, flush_code;
    logic [1:0]  ndata, rem_code, ph1, ph2;
    logic [3:0]  rem_bits;
    logic        flush;

    always_comb begin
        acc = {residual_bits_reg, data_byte};
        case (residual_count_reg)
            3'd0: begin
                g0         = acc[7:2];
                g1         = '0;
                ndata      = 2'd1;
                rem_code   = 2'd1;
                rem_bits   = {2'b00, acc[1:0]};
                flush_code = {acc[1:0], 4'b0000};
            end
            3'd2: begin
                g0         = acc[9:4];
                g1         = '0;
                ndata      = 2'd1;
                rem_code   = 2'd2;
                rem_bits   = acc[3:0];
                flush_code = {acc[3:0], 2'b00};
            end
            default: begin
                g0         = acc[11:6];
                g1         = acc[5:0];
                ndata      = 2'd2;
                rem_code   = 2'd0;
                rem_bits   = 4'd0;
                flush_code = '0;
            end
        endcase

        ph1   = symbol_phase_reg + ndata;
        flush = final_byte && (rem_code != 2'd0);
        ph2   = ph1 + {1'b0, flush};

        job.codes[0] = g0;
        job.codes[1] = (ndata == 2'd2) ? g1 : flush_code;
        job.codes[2] = flush_code;
        job.ncodes   = ndata + {1'b0, flush};
        job.npads    = final_byte ? (2'd0 - ph2) : 2'd0;
        job.fin      = final_byte;

        if (final_byte) begin
            residual_bits_next  = '0;
            residual_count_next = '0;
            symbol_phase_next   = '0;
        end else begin
            residual_bits_next  = rem_bits;
            residual_count_next = {rem_code, 1'b0};
            symbol_phase_next   = ph1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            residual_bits_reg  <= '0;
            residual_count_reg <= '0;
            symbol_phase_reg   <= '0;
        end else if (accept) begin
            residual_bits_reg  <= residual_bits_next;
            residual_count_reg <= residual_count_next;
            symbol_phase_reg   <= symbol_phase_next;
        end
    end

endmodule

[design/b64enc_queue.sv]
// Small show-ahead job queue between the front and back ends.
// Uses b64enc_pkg for the job type.
module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  b64enc_pkg::job_t  din,
    input  logic              rd_en,
    output b64enc_pkg::job_t  dout,
    output logic              empty,
    output logic              full
);
    import b64enc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);
    assign dout  = mem[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/b64enc_back.sv]
// Back end: steps through the head job one character per cycle into the output
// register, unless m_ready stalls. Uses b64enc_pkg for the job type, alphabet and pad code.
module b64enc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  b64enc_pkg::job_t  job,
    input  logic              job_valid,
    output logic              job_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_symbol,
    output logic              m_item_done,
    output logic              m_message_done
);
    import b64enc_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [6:0] m_symbol_reg;
    logic       m_item_done_reg;
    logic       m_message_done_reg;
    logic [2:0] total;
    logic       last;
    logic       load;
    logic [6:0] sym;

    always_comb begin
        total   = {1'b0, job.ncodes} + {1'b0, job.npads};
        last    = (idx_reg == total - 3'd1);
        load    = job_valid && (!m_valid_reg || m_ready);
        job_pop = load && last;
        sym     = (idx_reg < {1'b0, job.ncodes}) ? map6(job.codes[idx_reg[1:0]]) : PAD_CHAR;

        idx_next = idx_reg;
        if (load) begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end

        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_symbol_reg       <= sym;
            m_item_done_reg    <= last;
            m_message_done_reg <= last && job.fin;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_item_done    = m_item_done_reg;
    assign m_message_done = m_message_done_reg;

endmodule

[design/b64enc_checker.sv]
// Port-level checks for the base64 encoder result channel, bound to the top.
// Depends on base64_stream_encoder_core_macros.svh.
`include "base64_stream_encoder_core_macros.svh"

module b64enc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_symbol,
    input logic       m_item_done,
    input logic       m_message_done
);

    `B64_ASSERT_NEXT(a_m_valid_hold, m_valid && !m_ready, m_valid, "m_valid not held")
    `B64_ASSERT_NEXT(a_m_symbol_hold, m_valid && !m_ready, $stable(m_symbol), "m_symbol not held")
    `B64_ASSERT_NOW(a_msg_ends_item, m_valid && m_message_done, m_item_done, "lone message end")
    `B64_ASSERT_NOW(a_symbol_range, m_valid, m_symbol >= 7'd43 && m_symbol <= 7'd122, "bad symbol")

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker (.*);

[test/testbench.sv]
// Self-checking testbench for base64_stream_encoder_core: directed table, then random messages.
// Predicts every character, pad and end flag in step with each accepted request.
// Depends on b64enc_pkg and the design files only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64enc_pkg::*;

    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        logic [6:0] symbol;
        logic       item_done;
        logic       message_done;
    } b64_symbol_t;

    typedef struct packed {
        logic [7:0]      data;
        logic            fin;
        logic [2:0]      n_typed;
        logic [3:0][7:0] typed;
    } directed_row_t;

    typedef enum {MIX_STEADY, MIX_SENDER_IDLE, MIX_RECEIVER_STALL, MIX_BOTH_IDLE} mix_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_symbol;
    logic       m_item_done;
    logic       m_message_done;

    b64_symbol_t   pending_symbols[$];
    directed_row_t directed_rows [N_DIRECTED];
    logic [6:0]    enc_chars [4];
    logic [3:0]    carry_bits = '0;
    logic [2:0]    carry_count = '0;
    logic [1:0]    char_phase = '0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            requests_sent = 0;
    int            messages_sent = 0;
    int            symbols_checked = 0;
    int            fail_count = 0;

    base64_stream_encoder_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_final_byte   (s_final_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_item_done    (m_item_done),
        .m_message_done (m_message_done)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        return B64_ALPHABET[v][6:0];
    endfunction

    // Advance the encoder state by one byte; characters land in enc_chars.
    function automatic int encode_byte(input logic [7:0] d, input logic f);
        logic [11:0] acc;
        logic [11:0] grp;
        int          nbits;
        int          n;
        acc = {carry_bits, d};
        nbits = (carry_count > 3'd4) ? 12 : int'(carry_count) + 8;
        n = 0;
        while (nbits >= 6 && n < 4) begin
            grp = acc >> (nbits - 6);
            enc_chars[n] = b64_char(grp[5:0]);
            n++;
            nbits -= 6;
            char_phase = char_phase + 2'd1;
        end
        acc = acc & ((12'd1 << nbits) - 12'd1);
        if (f) begin
            if (nbits > 0 && n < 4) begin
                grp = acc << (6 - nbits);
                enc_chars[n] = b64_char(grp[5:0]);
                n++;
                char_phase = char_phase + 2'd1;
            end
            acc = '0;
            nbits = 0;
            while (char_phase != 2'd0 && n < 4) begin
                enc_chars[n] = PAD_CHAR;
                n++;
                char_phase = char_phase + 2'd1;
            end
            char_phase = 2'd0;
        end
        carry_bits = acc[3:0];
        carry_count = nbits[2:0];
        return n;
    endfunction

    task automatic send_request(input logic [7:0] d, input logic f, input logic [2:0] n_typed,
                                input logic [3:0][7:0] typed);
        int  n;
        bit  last;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_final_byte <= f;
        do @(posedge aclk); while (!s_ready);
        n = encode_byte(d, f);
        if (n_typed != 0) begin
            n = n_typed;
        end
        for (int k = 0; k < n; k++) begin
            last = (k == n - 1);
            if (n_typed != 0) begin
                pending_symbols.push_back('{typed[n - 1 - k][6:0], last, last && f});
            end else begin
                pending_symbols.push_back('{enc_chars[k], last, last && f});
            end
        end
        requests_sent++;
        if (f) begin
            messages_sent++;
        end
    endtask

    // Hold the sender until every predicted character has come out.
    task automatic drain_pending();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_symbols.size() != 0);
    endtask

    task automatic run_mix(input mix_t mix, input int n_requests);
        int         sent;
        int         len;
        int         r;
        logic [7:0] d;
        case (mix)
            MIX_STEADY: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            MIX_SENDER_IDLE: begin
                send_idle_pct = 69;
                recv_stall_pct = 0;
            end
            MIX_RECEIVER_STALL: begin
                send_idle_pct = 0;
                recv_stall_pct = 69;
            end
            default: begin
                send_idle_pct = 38;
                recv_stall_pct = 38;
            end
        endcase
        sent = 0;
        while (sent < n_requests) begin
            len = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 30);
            if (len > n_requests - sent) begin
                len = n_requests - sent;
            end
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(15);
                d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
                send_request(d, i == len - 1, 3'd0, '0);
                sent++;
            end
        end
        drain_pending();
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        b64_symbol_t want;
        b64_symbol_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_symbol, m_item_done, m_message_done};
            if (pending_symbols.size() == 0) begin
                $display("%0t: unexpected symbol=%0d item_done=%0b message_done=%0b",
                         $time, got.symbol, got.item_done, got.message_done);
                fail_count++;
            end else begin
                want = pending_symbols.pop_front();
                if (got.symbol !== want.symbol || got.item_done !== want.item_done ||
                    got.message_done !== want.message_done) begin
                    $display("%0t: mismatch expected symbol=%0d item_done=%0b message_done=%0b",
                             $time, want.symbol, want.item_done, want.message_done);
                    $display("%0t:          actual   symbol=%0d item_done=%0b message_done=%0b",
                             $time, got.symbol, got.item_done, got.message_done);
                    fail_count++;
                end
                symbols_checked++;
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        directed_rows = '{
            '{8'h00, 1'b1, 3'd4, "AA=="},
            '{8'hFF, 1'b1, 3'd4, "/w=="},
            '{8'hFF, 1'b0, 3'd1, 32'("/")},
            '{8'hFF, 1'b0, 3'd1, 32'("/")},
            '{8'hFF, 1'b1, 3'd2, 32'("//")},
            '{8'h00, 1'b0, 3'd1, 32'("A")},
            '{8'h00, 1'b0, 3'd1, 32'("A")},
            '{8'h00, 1'b0, 3'd2, 32'("AA")},
            '{8'h00, 1'b1, 3'd4, "AA=="},
            '{8'h4D, 1'b0, 3'd0, '0},
            '{8'h61, 1'b0, 3'd0, '0},
            '{8'h6E, 1'b1, 3'd0, '0},
            '{8'h4D, 1'b0, 3'd0, '0},
            '{8'h61, 1'b1, 3'd0, '0},
            '{8'h80, 1'b0, 3'd0, '0},
            '{8'h01, 1'b1, 3'd0, '0},
            '{8'h7F, 1'b0, 3'd0, '0},
            '{8'hFE, 1'b0, 3'd0, '0},
            '{8'h55, 1'b0, 3'd0, '0},
            '{8'hAA, 1'b1, 3'd0, '0},
            '{8'hFB, 1'b1, 3'd0, '0},
            '{8'hD3, 1'b0, 3'd0, '0},
            '{8'hE7, 1'b1, 3'd0, '0}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].data, directed_rows[i].fin,
                         directed_rows[i].n_typed, directed_rows[i].typed);
        end
        drain_pending();
        run_mix(MIX_STEADY, 85);
        run_mix(MIX_SENDER_IDLE, 85);
        run_mix(MIX_RECEIVER_STALL, 85);
        run_mix(MIX_BOTH_IDLE, 85);
        repeat (16) @(posedge aclk);
        $display("Sent %0d requests in %0d messages, checked %0d symbols", requests_sent,
                 messages_sent, symbols_checked);
        $display("Idle mixes: steady, sender idle, receiver stall, both; %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
